// ===== sv/wcr_pkg.sv =====
// wcr_pkg: shared types, weights and the sRGB linearisation table for the contrast ratio core
package wcr_pkg;

    localparam int CH_W       = 8;
    localparam int LIN_W      = 31;
    localparam int CONTRAST_W = 15;
    localparam int LUM_OUT_W  = 16;
    localparam int WEIGHT_W   = 16;
    localparam int PROD_W     = LIN_W + WEIGHT_W - 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 16'd13933;
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd46871;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 16'd4732;

    localparam logic [CONTRAST_W-1:0] CONTRAST_MAX = 15'h7FFF;
    localparam logic [LUM_OUT_W-1:0]  LUM_OUT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [CH_W-1:0] first_red;
        logic [CH_W-1:0] first_green;
        logic [CH_W-1:0] first_blue;
        logic [CH_W-1:0] second_red;
        logic [CH_W-1:0] second_green;
        logic [CH_W-1:0] second_blue;
    } t_colour_pair;

    typedef struct packed {
        logic [CONTRAST_W-1:0] contrast_q;
        logic [LUM_OUT_W-1:0]  first_luminance;
        logic [LUM_OUT_W-1:0]  second_luminance;
    } t_contrast_result;

    typedef logic [255:0][LIN_W-1:0] t_lin_table;

    // r^5 with truncating q30 products
    function automatic logic [63:0] fifth_power_q30(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        return (r4 * r) >> 30;
    endfunction

    // linear light of one 8-bit channel in q30, x^2.4 as x^2 * x^0.4
    function automatic logic [LIN_W-1:0] lin_q30(input logic [CH_W-1:0] v);
        logic [63:0] v64;
        logic [63:0] n;
        logic [63:0] xq;
        logic [63:0] t;
        logic [63:0] root;
        logic [63:0] cand;
        v64  = {56'd0, v};
        root = 64'd0;
        if (v64 <= 64'd10) begin
            return LIN_W'(((v64 * 64'd100) << 30) / 64'd329460);
        end
        n  = 64'd1000 * v64 + 64'd14025;
        xq = (n << 30) / 64'd269025;
        t  = (xq * xq) >> 30;
        for (int b = 30; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand <= (64'd1 << 30)) begin
                if (fifth_power_q30(cand) <= t) begin
                    root = cand;
                end
            end
        end
        return LIN_W'((t * root) >> 30);
    endfunction

    function automatic t_lin_table build_lin_table();
        t_lin_table tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = lin_q30(CH_W'(i));
        end
        return tab;
    endfunction

    localparam t_lin_table LIN_TABLE = build_lin_table();

endpackage

// ===== sv/wcag_contrast_ratio_core.sv =====
// wcag_contrast_ratio_core: two luminance lanes, a merge stage and a pipelined ratio divider
//
//  port          dir  kind     meaning
//  start         in   strobe   colour pair transfer, taken when busy is low
//  busy          out  level    always low, a pair is taken every cycle
//  i_operands    in   payload  t_colour_pair, both colours
//  o_valid       out  strobe   result transfer, high for a single cycle per result
//  o_result      out  payload  t_contrast_result, ratio and both luminances
//
// the pipeline holds four registers in each luminance lane, one merge register, one divider
// stage per quotient bit (RATIO_FRAC_BITS + 5) and one output register.
// a new pair enters every cycle; the divider is fully pipelined.
// reset clears only the valid flags, payload registers are left as they are.
// the receiver cannot stall, each result shows for a single cycle.
module wcag_contrast_ratio_core #(
    parameter int LUM_FRAC_BITS   = 16,
    parameter int RATIO_FRAC_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  wcr_pkg::t_colour_pair       i_operands,
    output logic                        o_valid,
    output wcr_pkg::t_contrast_result   o_result
);

    localparam int L   = LUM_FRAC_BITS;
    localparam int QB  = RATIO_FRAC_BITS + 5;
    localparam int NW  = L + RATIO_FRAC_BITS + 2;
    localparam int DW  = L + 2;
    localparam int SW  = 2 * L;
    localparam int QSW = (QB > wcr_pkg::CONTRAST_W) ? QB : wcr_pkg::CONTRAST_W;
    localparam int LSW = (L > wcr_pkg::LUM_OUT_W) ? L : wcr_pkg::LUM_OUT_W;
    localparam logic [L:0] OFF = (L + 1)'((((1 << L) - 1) + 10) / 20);

    logic           w_accept;
    logic           w_v1, w_v2;
    logic [L-1:0]   w_lum1, w_lum2;
    logic [L-1:0]   w_hi, w_lo;
    logic [L:0]     w_hi_off, w_den;

    logic           r_mv;
    logic [NW-1:0]  r_num;
    logic [DW-1:0]  r_den2;
    logic [SW-1:0]  r_lums;

    logic           w_valid [QB+1];
    logic [NW-1:0]  w_rem   [QB+1];
    logic [DW-1:0]  w_div   [QB+1];
    logic [QB-1:0]  w_quot  [QB+1];
    logic [SW-1:0]  w_side  [QB+1];

    logic [QSW-1:0] w_q_ext;
    logic [LSW-1:0] w_l1_ext, w_l2_ext;

    logic                       r_valid;
    wcr_pkg::t_contrast_result  r_result;
    wcr_pkg::t_contrast_result  n_result;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    wcr_lum_lane #(.LUM_FRAC_BITS(L)) u_lane_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_red   (i_operands.first_red),
        .i_green (i_operands.first_green),
        .i_blue  (i_operands.first_blue),
        .o_valid (w_v1),
        .o_lum   (w_lum1)
    );

    wcr_lum_lane #(.LUM_FRAC_BITS(L)) u_lane_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_red   (i_operands.second_red),
        .i_green (i_operands.second_green),
        .i_blue  (i_operands.second_blue),
        .o_valid (w_v2),
        .o_lum   (w_lum2)
    );

    // merge: lighter over darker, rounding folded in as (2n + d) / 2d
    assign w_hi     = (w_lum1 > w_lum2) ? w_lum1 : w_lum2;
    assign w_lo     = (w_lum1 > w_lum2) ? w_lum2 : w_lum1;
    assign w_hi_off = {1'b0, w_hi} + OFF;
    assign w_den    = {1'b0, w_lo} + OFF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= w_v1 && w_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= {w_hi_off, {(RATIO_FRAC_BITS + 1){1'b0}}} + NW'(w_den);
        r_den2 <= {w_den, 1'b0};
        r_lums <= {w_lum1, w_lum2};
    end

    assign w_valid[0] = r_mv;
    assign w_rem[0]   = r_num;
    assign w_div[0]   = r_den2;
    assign w_quot[0]  = '0;
    assign w_side[0]  = r_lums;

    for (genvar k = 0; k < QB; k++) begin : g_div
        wcr_div_stage #(
            .NW    (NW),
            .DW    (DW),
            .QB    (QB),
            .SHIFT (QB - 1 - k),
            .SW    (SW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_rem   (w_rem[k]),
            .i_div   (w_div[k]),
            .i_quot  (w_quot[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_div   (w_div[k+1]),
            .o_quot  (w_quot[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    // clamp to the output field widths
    assign w_q_ext  = QSW'(w_quot[QB]);
    assign w_l1_ext = LSW'(w_side[QB][SW-1:L]);
    assign w_l2_ext = LSW'(w_side[QB][L-1:0]);

    always_comb begin
        n_result.contrast_q = (w_q_ext > QSW'(wcr_pkg::CONTRAST_MAX)) ?
                              wcr_pkg::CONTRAST_MAX : w_q_ext[wcr_pkg::CONTRAST_W-1:0];
        n_result.first_luminance = (w_l1_ext > LSW'(wcr_pkg::LUM_OUT_MAX)) ?
                              wcr_pkg::LUM_OUT_MAX : w_l1_ext[wcr_pkg::LUM_OUT_W-1:0];
        n_result.second_luminance = (w_l2_ext > LSW'(wcr_pkg::LUM_OUT_MAX)) ?
                              wcr_pkg::LUM_OUT_MAX : w_l2_ext[wcr_pkg::LUM_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== sv/wcr_lum_lane.sv =====
// wcr_lum_lane: one colour's relative luminance, table lookup then weighted sum and scaling
module wcr_lum_lane #(
    parameter int LUM_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [wcr_pkg::CH_W-1:0]    i_red,
    input  logic [wcr_pkg::CH_W-1:0]    i_green,
    input  logic [wcr_pkg::CH_W-1:0]    i_blue,
    output logic                        o_valid,
    output logic [LUM_FRAC_BITS-1:0]    o_lum
);

    localparam int SUM_W = wcr_pkg::PROD_W + 1;
    localparam int PW    = wcr_pkg::LIN_W + LUM_FRAC_BITS;

    logic [3:0]                     r_valid;
    logic [wcr_pkg::LIN_W-1:0]      r_lin_r, r_lin_g, r_lin_b;
    logic [wcr_pkg::PROD_W-1:0]     r_prod_r, r_prod_g, r_prod_b;
    logic [wcr_pkg::LIN_W-1:0]      r_y30;
    logic [LUM_FRAC_BITS-1:0]       r_lum;
    logic [SUM_W-1:0]               w_sum;
    logic [PW-1:0]                  w_scaled;

    assign w_sum = SUM_W'(r_prod_r) + SUM_W'(r_prod_g) + SUM_W'(r_prod_b)
                 + SUM_W'(1 << 15);

    // y30 * (2^L - 1) as a shift and subtract, then round to L bits
    assign w_scaled = {r_y30, {LUM_FRAC_BITS{1'b0}}} - PW'(r_y30) + PW'(1 << 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lin_r  <= wcr_pkg::LIN_TABLE[i_red];
        r_lin_g  <= wcr_pkg::LIN_TABLE[i_green];
        r_lin_b  <= wcr_pkg::LIN_TABLE[i_blue];
        r_prod_r <= wcr_pkg::PROD_W'(r_lin_r) * wcr_pkg::PROD_W'(wcr_pkg::WEIGHT_RED);
        r_prod_g <= wcr_pkg::PROD_W'(r_lin_g) * wcr_pkg::PROD_W'(wcr_pkg::WEIGHT_GREEN);
        r_prod_b <= wcr_pkg::PROD_W'(r_lin_b) * wcr_pkg::PROD_W'(wcr_pkg::WEIGHT_BLUE);
        r_y30    <= w_sum[SUM_W-1:16];
        r_lum    <= w_scaled[29+LUM_FRAC_BITS:30];
    end

    assign o_valid = r_valid[3];
    assign o_lum   = r_lum;

endmodule

// ===== sv/wcr_div_stage.sv =====
// wcr_div_stage: one restoring division step, decides one quotient bit
module wcr_div_stage #(
    parameter int NW    = 28,
    parameter int DW    = 18,
    parameter int QB    = 15,
    parameter int SHIFT = 0,
    parameter int SW    = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_rem,
    input  logic [DW-1:0]   i_div,
    input  logic [QB-1:0]   i_quot,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [NW-1:0]   o_rem,
    output logic [DW-1:0]   o_div,
    output logic [QB-1:0]   o_quot,
    output logic [SW-1:0]   o_side
);

    localparam int WW = DW + QB + NW;

    logic            r_valid;
    logic [NW-1:0]   r_rem;
    logic [DW-1:0]   r_div;
    logic [QB-1:0]   r_quot;
    logic [SW-1:0]   r_side;
    logic [WW-1:0]   w_sub;
    logic            w_take;

    assign w_sub  = WW'(i_div) << SHIFT;
    assign w_take = WW'(i_rem) >= w_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= w_take ? NW'(WW'(i_rem) - w_sub) : i_rem;
        r_quot <= i_quot | (w_take ? (QB'(1) << SHIFT) : QB'(0));
        r_div  <= i_div;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quot  = r_quot;
    assign o_side  = r_side;

endmodule
